@@ src/scalar_kalman_estimator_assert.svh @@
// assertion macros shared by the estimator rtl
`ifndef SCALAR_KALMAN_ESTIMATOR_ASSERT_SVH
`define SCALAR_KALMAN_ESTIMATOR_ASSERT_SVH

// same-cycle implication
`define SKE_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ske: same-cycle check failed");

// next-cycle implication
`define SKE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ske: next-cycle check failed");

`endif

@@ src/ske_pkg.sv @@
`default_nettype none

package ske_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF = 16;
   localparam int NOISE_RESET = 655;

   // register indexes
   localparam int CSR_COUNT = 3;
   localparam int CSR_INDEX_W = $clog2(CSR_COUNT);
   localparam logic [CSR_INDEX_W-1:0] CSR_MEASURE_ERROR = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_INITIAL_ERROR = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_PROCESS_NOISE = CSR_INDEX_W'(2);

   // datapath operations
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_NOP      = 3'd0;
   localparam logic [OP_W-1:0] OP_ACCEPT   = 3'd1;
   localparam logic [OP_W-1:0] OP_DIV_STEP = 3'd2;
   localparam logic [OP_W-1:0] OP_GAIN     = 3'd3;
   localparam logic [OP_W-1:0] OP_MUL_STEP = 3'd4;
   localparam logic [OP_W-1:0] OP_DELTA    = 3'd5;
   localparam logic [OP_W-1:0] OP_T1       = 3'd6;
   localparam logic [OP_W-1:0] OP_FINISH   = 3'd7;

   // jump conditions
   localparam int COND_W = 3;
   localparam logic [COND_W-1:0] COND_NEVER      = 3'd0;
   localparam logic [COND_W-1:0] COND_ALWAYS     = 3'd1;
   localparam logic [COND_W-1:0] COND_NO_REQ     = 3'd2;
   localparam logic [COND_W-1:0] COND_COUNT_MORE = 3'd3;
   localparam logic [COND_W-1:0] COND_OUT_FULL   = 3'd4;

   // program steps
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_IDLE   = 4'd0;
   localparam logic [STEP_W-1:0] STEP_DIV    = 4'd1;
   localparam logic [STEP_W-1:0] STEP_GAIN   = 4'd2;
   localparam logic [STEP_W-1:0] STEP_MULK   = 4'd3;
   localparam logic [STEP_W-1:0] STEP_DELTA  = 4'd4;
   localparam logic [STEP_W-1:0] STEP_MULP   = 4'd5;
   localparam logic [STEP_W-1:0] STEP_T1     = 4'd6;
   localparam logic [STEP_W-1:0] STEP_MULQ   = 4'd7;
   localparam logic [STEP_W-1:0] STEP_FINISH = 4'd8;
   localparam logic [STEP_W-1:0] STEP_DONE   = 4'd9;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [COND_W-1:0] cond;
      logic [STEP_W-1:0] target;
   } ctl_word_type;

   typedef struct packed {
      logic req_valid;
      logic count_more;
      logic out_full;
   } stat_type;

   // microcode rom
   function automatic ctl_word_type ucode(input logic [STEP_W-1:0] step);
      ctl_word_type w;
      unique case (step)
         STEP_IDLE:   w = '{op: OP_ACCEPT,   cond: COND_NO_REQ,     target: STEP_IDLE};
         STEP_DIV:    w = '{op: OP_DIV_STEP, cond: COND_COUNT_MORE, target: STEP_DIV};
         STEP_GAIN:   w = '{op: OP_GAIN,     cond: COND_NEVER,      target: STEP_IDLE};
         STEP_MULK:   w = '{op: OP_MUL_STEP, cond: COND_COUNT_MORE, target: STEP_MULK};
         STEP_DELTA:  w = '{op: OP_DELTA,    cond: COND_NEVER,      target: STEP_IDLE};
         STEP_MULP:   w = '{op: OP_MUL_STEP, cond: COND_COUNT_MORE, target: STEP_MULP};
         STEP_T1:     w = '{op: OP_T1,       cond: COND_NEVER,      target: STEP_IDLE};
         STEP_MULQ:   w = '{op: OP_MUL_STEP, cond: COND_COUNT_MORE, target: STEP_MULQ};
         STEP_FINISH: w = '{op: OP_FINISH,   cond: COND_OUT_FULL,   target: STEP_FINISH};
         STEP_DONE:   w = '{op: OP_NOP,      cond: COND_ALWAYS,     target: STEP_IDLE};
         default:     w = '{op: OP_NOP,      cond: COND_ALWAYS,     target: STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

@@ src/ske_req_if.sv @@
`default_nettype none

interface ske_req_if #(
   parameter int DATA_WIDTH = ske_pkg::DATA_WIDTH_DEF
) ();
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] measurement;

   modport source (output valid, output measurement, input ready);
   modport sink (input valid, input measurement, output ready);
endinterface

`default_nettype wire

@@ src/ske_rsp_if.sv @@
`default_nettype none

interface ske_rsp_if #(
   parameter int DATA_WIDTH = ske_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = ske_pkg::FRAC_BITS_DEF
) ();
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] estimate;
   logic [FRAC_BITS:0]           gain;

   modport source (output valid, output estimate, output gain, input ready);
   modport sink (input valid, input estimate, input gain, output ready);
endinterface

`default_nettype wire

@@ src/ske_sequencer.sv @@
`default_nettype none

module ske_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  ske_pkg::stat_type     stat,
   output ske_pkg::ctl_word_type ctl
);
   import ske_pkg::*;

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic              take_jump;

   assign ctl = ucode(step_ff);

   always_comb begin
      unique case (ctl.cond)
         COND_ALWAYS:     take_jump = 1'b1;
         COND_NO_REQ:     take_jump = !stat.req_valid;
         COND_COUNT_MORE: take_jump = stat.count_more;
         COND_OUT_FULL:   take_jump = stat.out_full;
         default:         take_jump = 1'b0;
      endcase
      step_in = take_jump ? ctl.target : step_ff + STEP_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

`default_nettype wire

@@ src/ske_datapath.sv @@
`default_nettype none
`include "scalar_kalman_estimator_assert.svh"

module ske_datapath #(
   parameter int DATA_WIDTH = ske_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = ske_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ske_pkg::ctl_word_type                ctl,
   output ske_pkg::stat_type                    stat,
   input  logic                                req_valid,
   input  logic signed [DATA_WIDTH-1:0]        req_measurement,
   input  logic                                csr_write_enable,
   input  logic [ske_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [DATA_WIDTH-1:0]               csr_write_data,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic signed [DATA_WIDTH-1:0]        rsp_estimate,
   output logic [FRAC_BITS:0]                  rsp_gain
);
   import ske_pkg::*;

   localparam int DW = DATA_WIDTH;
   localparam int FW = FRAC_BITS;
   localparam int GW = FW + 1;
   localparam int BW = (DW >= GW) ? DW : GW;
   localparam int PW = DW + BW;
   localparam int CW = $clog2(BW + 1);
   localparam int DIV_STEPS = FW;
   localparam int GAIN_MUL_STEPS = (GW + 1) / 2;
   localparam int NOISE_MUL_STEPS = (DW + 1) / 2;
   localparam logic [GW-1:0] GAIN_ONE = {1'b1, {FW{1'b0}}};
   localparam logic [DW-1:0] ONE_INIT = DW'(GAIN_ONE);
   localparam logic [DW-1:0] NOISE_INIT = DW'(NOISE_RESET);

   // configuration and filter state
   logic [DW-1:0]   r_ff, r_in;
   logic [DW-1:0]   pinit_ff, pinit_in;
   logic [DW-1:0]   q_ff, q_in;
   logic [DW-1:0]   last_ff, last_in;
   logic [DW-1:0]   p_ff, p_in;

   // per-item working registers
   logic [DW:0]     sum_ff, sum_in;
   logic [DW-1:0]   mag_ff, mag_in;
   logic            neg_ff, neg_in;
   logic [DW:0]     rem_ff, rem_in;
   logic [FW-1:0]   quot_ff, quot_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [GW-1:0]   gain_ff, gain_in;
   logic [DW-1:0]   est_ff, est_in;
   logic [DW-1:0]   delta_ff, delta_in;
   logic [DW-1:0]   t1_ff, t1_in;
   logic [PW-1:0]   mcand_ff, mcand_in;
   logic [BW-1:0]   mplier_ff, mplier_in;
   logic [PW-1:0]   acc_ff, acc_in;

   // result register
   logic            rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]   rsp_est_ff, rsp_est_in;
   logic [GW-1:0]   rsp_gain_ff, rsp_gain_in;

   // combinational helpers
   logic [DW:0]     diff;
   logic [DW:0]     mag_full;
   logic [DW+1:0]   rem2;
   logic [DW+1:0]   rem_sub;
   logic            rem_ge;
   logic [GW-1:0]   gain_sel;
   logic [PW-1:0]   pp0;
   logic [PW-1:0]   pp1;
   logic [DW-1:0]   delta_w;
   logic [DW-1:0]   t2_sat;
   logic [DW:0]     np;
   logic            csr_hit;

   always_comb begin
      r_in        = r_ff;
      pinit_in    = pinit_ff;
      q_in        = q_ff;
      last_in     = last_ff;
      p_in        = p_ff;
      sum_in      = sum_ff;
      mag_in      = mag_ff;
      neg_in      = neg_ff;
      rem_in      = rem_ff;
      quot_in     = quot_ff;
      count_in    = count_ff;
      gain_in     = gain_ff;
      est_in      = est_ff;
      delta_in    = delta_ff;
      t1_in       = t1_ff;
      mcand_in    = mcand_ff;
      mplier_in   = mplier_ff;
      acc_in      = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_est_in  = rsp_est_ff;
      rsp_gain_in = rsp_gain_ff;

      diff     = {req_measurement[DW-1], req_measurement} - {last_ff[DW-1], last_ff};
      mag_full = diff[DW] ? (~diff + (DW+1)'(1)) : diff;

      // restoring divide, one quotient bit per step
      rem2    = {rem_ff, 1'b0};
      rem_sub = rem2 - {1'b0, sum_ff};
      rem_ge  = rem2 >= {1'b0, sum_ff};

      if (sum_ff == '0) begin
         gain_sel = '0;
      end else if ({1'b0, p_ff} >= sum_ff) begin
         gain_sel = GAIN_ONE;
      end else begin
         gain_sel = {1'b0, quot_ff};
      end

      // two multiplier bits per step
      pp0 = mplier_ff[0] ? mcand_ff : '0;
      pp1 = mplier_ff[1] ? {mcand_ff[PW-2:0], 1'b0} : '0;

      delta_w = acc_ff[FW +: DW];
      t2_sat  = (|acc_ff[PW-1:FW+DW]) ? '1 : acc_ff[FW +: DW];
      np      = {1'b0, t1_ff} + {1'b0, t2_sat};

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (ctl.op)
         OP_ACCEPT: begin
            if (req_valid) begin
               sum_in   = {1'b0, p_ff} + {1'b0, r_ff};
               neg_in   = diff[DW];
               mag_in   = mag_full[DW-1:0];
               rem_in   = {1'b0, p_ff};
               quot_in  = '0;
               count_in = CW'(DIV_STEPS);
            end
         end
         OP_DIV_STEP: begin
            rem_in   = rem_ge ? rem_sub[DW:0] : rem2[DW:0];
            quot_in  = {quot_ff[FW-2:0], rem_ge};
            count_in = count_ff - CW'(1);
         end
         OP_GAIN: begin
            gain_in   = gain_sel;
            mcand_in  = PW'(mag_ff);
            mplier_in = BW'(gain_sel);
            acc_in    = '0;
            count_in  = CW'(GAIN_MUL_STEPS);
         end
         OP_MUL_STEP: begin
            acc_in    = acc_ff + pp0 + pp1;
            mcand_in  = {mcand_ff[PW-3:0], 2'b00};
            mplier_in = {2'b00, mplier_ff[BW-1:2]};
            count_in  = count_ff - CW'(1);
         end
         OP_DELTA: begin
            delta_in  = delta_w;
            est_in    = neg_ff ? (last_ff - delta_w) : (last_ff + delta_w);
            mcand_in  = PW'(p_ff);
            mplier_in = BW'(GAIN_ONE - gain_ff);
            acc_in    = '0;
            count_in  = CW'(GAIN_MUL_STEPS);
         end
         OP_T1: begin
            t1_in     = acc_ff[FW +: DW];
            mcand_in  = PW'(q_ff);
            mplier_in = BW'(delta_ff);
            acc_in    = '0;
            count_in  = CW'(NOISE_MUL_STEPS);
         end
         OP_FINISH: begin
            if (!rsp_valid_ff) begin
               p_in         = np[DW] ? '1 : np[DW-1:0];
               last_in      = est_ff;
               rsp_valid_in = 1'b1;
               rsp_est_in   = est_ff;
               rsp_gain_in  = gain_ff;
            end
         end
         default: begin
         end
      endcase

      // register write reloads the error and clears the estimate
      csr_hit = csr_write_enable &&
                ((csr_index == CSR_MEASURE_ERROR) || (csr_index == CSR_INITIAL_ERROR) ||
                 (csr_index == CSR_PROCESS_NOISE));
      if (csr_hit) begin
         if (csr_index == CSR_MEASURE_ERROR) begin
            r_in = csr_write_data;
         end
         if (csr_index == CSR_INITIAL_ERROR) begin
            pinit_in = csr_write_data;
         end
         if (csr_index == CSR_PROCESS_NOISE) begin
            q_in = csr_write_data;
         end
         p_in    = (csr_index == CSR_INITIAL_ERROR) ? csr_write_data : pinit_ff;
         last_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_ff         <= ONE_INIT;
         pinit_ff     <= ONE_INIT;
         q_ff         <= NOISE_INIT;
         last_ff      <= '0;
         p_ff         <= ONE_INIT;
         count_ff     <= CW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         r_ff         <= r_in;
         pinit_ff     <= pinit_in;
         q_ff         <= q_in;
         last_ff      <= last_in;
         p_ff         <= p_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff      <= sum_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      rem_ff      <= rem_in;
      quot_ff     <= quot_in;
      gain_ff     <= gain_in;
      est_ff      <= est_in;
      delta_ff    <= delta_in;
      t1_ff       <= t1_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      acc_ff      <= acc_in;
      rsp_est_ff  <= rsp_est_in;
      rsp_gain_ff <= rsp_gain_in;
   end

   assign stat.req_valid  = req_valid;
   assign stat.count_more = (count_ff != CW'(1));
   assign stat.out_full   = rsp_valid_ff;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_estimate = rsp_est_ff;
   assign rsp_gain     = rsp_gain_ff;

   `SKE_ASSERT_IMPLIES(a_gain_bound, clock, reset, rsp_valid_ff, rsp_gain_ff <= GAIN_ONE)
   `SKE_ASSERT_NEXT(a_commit_fills, clock, reset, (ctl.op == OP_FINISH) && !rsp_valid_ff, rsp_valid_ff)
   `SKE_ASSERT_IMPLIES(a_loop_count, clock, reset, (ctl.op == OP_DIV_STEP) || (ctl.op == OP_MUL_STEP), count_ff != '0)

endmodule

`default_nettype wire

@@ src/scalar_kalman_estimator.sv @@
// a word is accepted in the idle step; its result goes through the bit-serial divide and three
//   2-bit multiplies, then is written to the result register once that register is empty
// a new word is taken only after the last has been written to the result register, so the
//   next word is taken while a finished result waits
// reset: synchronous active-high reset restores R=1.0, P0=1.0, q=655, estimate 0, P=1.0
`default_nettype none

module scalar_kalman_estimator #(
   parameter int DATA_WIDTH = ske_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = ske_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   ske_req_if.sink                         req_chan,
   ske_rsp_if.source                       rsp_chan,
   input  logic                            csr_write_enable,
   input  logic [ske_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [DATA_WIDTH-1:0]           csr_write_data
);
   import ske_pkg::*;

   // control word from the rom and status back from the datapath
   ctl_word_type ctl;
   stat_type     stat;

   // step counter, rom and conditional jumps
   ske_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctl   (ctl)
   );

   // shared divider / multiplier datapath, filter state and result register
   ske_datapath #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .stat             (stat),
      .req_valid        (req_chan.valid),
      .req_measurement  (req_chan.measurement),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_estimate     (rsp_chan.estimate),
      .rsp_gain         (rsp_chan.gain)
   );

   // a word is taken only in the idle step of the program
   assign req_chan.ready = (ctl.op == OP_ACCEPT);

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
   import ske_pkg::*;

   localparam int DW = DATA_WIDTH_DEF;
   localparam int FB = FRAC_BITS_DEF;

   // run length and drain bounds, in clock cycles
   localparam int LIMIT_CYCLES    = 500000;
   localparam int DRAIN_BOUND     = 20000;
   localparam int SETTLE_CYCLES   = 80;
   localparam int IDLE_GUARD      = 4;
   localparam int RANDOM_PHASES   = 8;
   localparam int WORDS_PER_PHASE = 100;

   // index one past the register list, must be ignored by the block
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = CSR_INDEX_W'(3);

   localparam logic [63:0] DATA_MAX = (64'd1 << DW) - 64'd1;
   localparam logic [63:0] UNITY_Q  = 64'd1 << FB;

   typedef struct packed {
      logic [DW-1:0] estimate;
      logic [FB:0]   gain;
   } est_result_type;

   typedef enum logic {ROW_CSR, ROW_WORD} row_kind_type;

   typedef struct packed {
      row_kind_type            kind;
      logic [CSR_INDEX_W-1:0]  index;
      logic [DW-1:0]           value;
      logic                    typed;
      est_result_type          want;
   } dir_row_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [DW-1:0] csr_write_data;

   ske_req_if #(.DATA_WIDTH(DW)) req_bus ();
   ske_rsp_if #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) rsp_bus ();

   scalar_kalman_estimator #(
      .DATA_WIDTH(DW),
      .FRAC_BITS(FB)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // filter state mirrored on the testbench side
   logic [DW-1:0] noise_r;
   logic [DW-1:0] start_p;
   logic [DW-1:0] noise_q;
   logic [DW-1:0] last_est;
   logic [DW-1:0] err_p;

   est_result_type estimate_q[$];
   dir_row_type    dir_rows[$];

   logic no_stall;
   int   fail_count;
   int   words_sent;
   int   results_seen;
   int   csr_writes;

   // clock, 2 ns period
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------

   // floor(a*b / 2^FB) clamped to cap
   function automatic logic [63:0] scaled_product(input logic [63:0] a, input logic [63:0] b,
                                                  input logic [63:0] cap);
      logic [127:0] full;
      logic [127:0] shifted;
      full = {64'd0, a} * {64'd0, b};
      shifted = full >> FB;
      return (shifted > {64'd0, cap}) ? cap : shifted[63:0];
   endfunction

   // truncated quotient p/s in q1.FB, one when p reaches s
   function automatic logic [63:0] gain_ratio(input logic [63:0] p, input logic [63:0] s);
      if (p >= s)
         return UNITY_Q;
      return (p << FB) / s;
   endfunction

   // one filter update: returns the result and advances the mirrored state
   function automatic est_result_type predict_update(input logic [DW-1:0] meas_bits);
      est_result_type r;
      longint meas;
      longint prev;
      longint diff;
      longint nxt;
      logic [63:0] p;
      logic [63:0] sum;
      logic [63:0] g;
      logic [63:0] mag;
      logic [63:0] delta;
      logic [63:0] t1;
      logic [63:0] t2;
      logic [63:0] np;
      meas = longint'($signed(meas_bits));
      prev = longint'($signed(last_est));
      p = 64'(err_p);
      sum = p + 64'(noise_r);
      // zero denominator gives zero gain
      g = (sum == 64'd0) ? 64'd0 : gain_ratio(p, sum);
      diff = meas - prev;
      mag = (diff < 0) ? 64'(-diff) : 64'(diff);
      // step truncates toward zero, so it never passes the measurement
      delta = scaled_product(g, mag, mag);
      nxt = (diff < 0) ? prev - longint'(delta) : prev + longint'(delta);
      t1 = scaled_product(UNITY_Q - g, p, DATA_MAX);
      t2 = scaled_product(delta, 64'(noise_q), DATA_MAX);
      np = t1 + t2;
      // error saturates at the unsigned maximum
      err_p = (np > DATA_MAX) ? DATA_MAX[DW-1:0] : np[DW-1:0];
      last_est = DW'(nxt);
      r.estimate = last_est;
      r.gain = g[FB:0];
      return r;
   endfunction

   // register write: any mapped index reloads p and clears the estimate
   function automatic void csr_effect(input logic [CSR_INDEX_W-1:0] idx,
                                      input logic [DW-1:0] val);
      case (idx)
         CSR_MEASURE_ERROR: noise_r = val;
         CSR_INITIAL_ERROR: start_p = val;
         CSR_PROCESS_NOISE: noise_q = val;
         default: return;
      endcase
      err_p = start_p;
      last_est = '0;
   endfunction

   // ------------------------------------------------------------------
   // directed table rows
   // ------------------------------------------------------------------

   function automatic dir_row_type csr_row(input logic [CSR_INDEX_W-1:0] idx,
                                           input logic [DW-1:0] val);
      dir_row_type r;
      r = '0;
      r.kind = ROW_CSR;
      r.index = idx;
      r.value = val;
      return r;
   endfunction

   function automatic dir_row_type word_row(input logic [DW-1:0] meas);
      dir_row_type r;
      r = '0;
      r.kind = ROW_WORD;
      r.value = meas;
      return r;
   endfunction

   function automatic dir_row_type typed_row(input logic [DW-1:0] meas,
                                             input logic [DW-1:0] est,
                                             input logic [FB:0] gain);
      dir_row_type r;
      r = word_row(meas);
      r.typed = 1'b1;
      r.want.estimate = est;
      r.want.gain = gain;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------

   // offer one measurement word, hold until taken, then queue its expected result
   task automatic send_word(input logic [DW-1:0] meas, input logic typed,
                            input est_result_type want);
      est_result_type pred;
      if (!no_stall && $urandom_range(0, 2) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.measurement <= meas;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      // accepted at this edge; the predictor advances even for typed rows
      pred = predict_update(meas);
      estimate_q.push_back(typed ? want : pred);
      words_sent++;
   endtask

   // register write, only once the block has drained
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [DW-1:0] val);
      req_bus.valid <= 1'b0;
      while (estimate_q.size() != 0) @(posedge clock);
      repeat (IDLE_GUARD) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      csr_effect(idx, val);
      csr_writes++;
   endtask

   // register value mix: extremes, powers of two, near unity, anything
   function automatic logic [DW-1:0] pick_csr_value();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return DW'(64'd1 << $urandom_range(0, DW - 1));
         3: return DW'($urandom_range(0, 32'h0004_0000));
         default: return DW'($urandom());
      endcase
   endfunction

   // measurement mix: extremes, full range, and noise around the running estimate
   function automatic logic [DW-1:0] pick_measurement();
      logic [DW-1:0] v;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: v = {1'b0, {(DW-1){1'b1}}};
               1: v = {1'b1, {(DW-1){1'b0}}};
               2: v = '0;
               default: v = '1;
            endcase
         end
         1, 2, 3: v = DW'($urandom());
         default: v = last_est + DW'($urandom_range(0, 32'h000F_FFFF)) - DW'(32'h0008_0000);
      endcase
      return v;
   endfunction

   // result side back-pressure in random bursts
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         if (!no_stall && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   // ------------------------------------------------------------------
   // result checker
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      est_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (estimate_q.size() == 0) begin
            $error("unexpected result word: estimate %h gain %h",
                   rsp_bus.estimate, rsp_bus.gain);
            fail_count++;
         end else begin
            want = estimate_q.pop_front();
            if (rsp_bus.estimate !== want.estimate) begin
               $error("estimate: expected %h, actual %h", want.estimate, rsp_bus.estimate);
               fail_count++;
            end
            if (rsp_bus.gain !== want.gain) begin
               $error("gain: expected %h, actual %h", want.gain, rsp_bus.gain);
               fail_count++;
            end
         end
      end
   end

   // backstop on a hung handshake
   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("timeout after %0d cycles, %0d results outstanding",
               LIMIT_CYCLES, estimate_q.size());
      $display("** scalar_kalman_estimator: FAILED **");
      $finish;
   end

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------

   initial begin
      est_result_type none;
      int waited;
      int n;
      none = '0;
      reset <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index <= '0;
      csr_write_data <= '0;
      req_bus.valid <= 1'b0;
      req_bus.measurement <= '0;
      no_stall = 1'b0;
      fail_count = 0;
      words_sent = 0;
      results_seen = 0;
      csr_writes = 0;

      // reset values of the mirrored state
      noise_r = DW'(32'h0001_0000);
      start_p = DW'(32'h0001_0000);
      noise_q = DW'(NOISE_RESET);
      err_p = start_p;
      last_est = '0;

      // first step after reset: gain one half, estimate halfway to 1.0
      dir_rows.push_back(typed_row(32'h0001_0000, 32'h0000_8000, 17'h0_8000));
      dir_rows.push_back(word_row(32'hFFFF_0000));
      dir_rows.push_back(word_row(32'h0000_0001));
      // unmapped index leaves state alone
      dir_rows.push_back(csr_row(CSR_UNMAPPED, 32'hDEAD_BEEF));
      dir_rows.push_back(word_row(32'h7FFF_FFFF));
      // r of zero: gain one, estimate jumps to the measurement
      dir_rows.push_back(csr_row(CSR_MEASURE_ERROR, 32'h0000_0000));
      dir_rows.push_back(typed_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 17'h1_0000));
      dir_rows.push_back(typed_row(32'h8000_0000, 32'h8000_0000, 17'h1_0000));
      // p and r both zero: zero denominator, estimate frozen
      dir_rows.push_back(csr_row(CSR_INITIAL_ERROR, 32'h0000_0000));
      dir_rows.push_back(typed_row(32'h1234_5678, 32'h0000_0000, 17'h0_0000));
      dir_rows.push_back(typed_row(32'h8000_0000, 32'h0000_0000, 17'h0_0000));
      // p zero with r nonzero: quotient zero
      dir_rows.push_back(csr_row(CSR_MEASURE_ERROR, 32'h0001_0000));
      dir_rows.push_back(typed_row(32'h7FFF_FFFF, 32'h0000_0000, 17'h0_0000));
      // all-ones p and q with r at zero drive the error update into saturation
      dir_rows.push_back(csr_row(CSR_PROCESS_NOISE, 32'hFFFF_FFFF));
      dir_rows.push_back(csr_row(CSR_INITIAL_ERROR, 32'hFFFF_FFFF));
      dir_rows.push_back(csr_row(CSR_MEASURE_ERROR, 32'h0000_0000));
      dir_rows.push_back(typed_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 17'h1_0000));
      dir_rows.push_back(typed_row(32'h8000_0000, 32'h8000_0000, 17'h1_0000));
      // p equals r at max: gain exactly one half, step truncated
      dir_rows.push_back(csr_row(CSR_MEASURE_ERROR, 32'hFFFF_FFFF));
      dir_rows.push_back(typed_row(32'h7FFF_FFFF, 32'h3FFF_FFFF, 17'h0_8000));
      dir_rows.push_back(word_row(32'hFFFF_FFFF));
      // no process noise, zero difference
      dir_rows.push_back(csr_row(CSR_PROCESS_NOISE, 32'h0000_0000));
      dir_rows.push_back(typed_row(32'h0000_0000, 32'h0000_0000, 17'h0_8000));
      dir_rows.push_back(word_row(32'hFFFF_FFFF));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR)
            write_csr(dir_rows[i].index, dir_rows[i].value);
         else
            send_word(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);
      end

      // random phases, each under a fresh register setting
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         if (ph == 0) begin
            // everything at the top end
            write_csr(CSR_MEASURE_ERROR, '1);
            write_csr(CSR_INITIAL_ERROR, '1);
            write_csr(CSR_PROCESS_NOISE, '1);
         end else if (ph == 1) begin
            // r and q at zero, p anywhere
            write_csr(CSR_MEASURE_ERROR, '0);
            write_csr(CSR_PROCESS_NOISE, '0);
            write_csr(CSR_INITIAL_ERROR, pick_csr_value());
         end else begin
            if ($urandom_range(0, 2) != 0) write_csr(CSR_MEASURE_ERROR, pick_csr_value());
            if ($urandom_range(0, 2) != 0) write_csr(CSR_PROCESS_NOISE, pick_csr_value());
            if ($urandom_range(0, 3) == 0) write_csr(CSR_UNMAPPED, DW'($urandom()));
            write_csr(CSR_INITIAL_ERROR, pick_csr_value());
         end
         // last phase runs with no idling on either side
         if (ph == RANDOM_PHASES - 1)
            no_stall = 1'b1;
         n = WORDS_PER_PHASE;
         for (int k = 0; k < n; k++)
            send_word(pick_measurement(), 1'b0, none);
      end
      req_bus.valid <= 1'b0;

      // drain, then watch a while longer for stray results
      waited = 0;
      while (estimate_q.size() != 0 && waited < DRAIN_BOUND) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (estimate_q.size() != 0) begin
         $error("%0d expected results never arrived", estimate_q.size());
         fail_count++;
      end

      $display("covered %0d measurement words and %0d register writes, %0d results checked",
               words_sent, csr_writes, results_seen);
      $display("register settings included all-zero and all-ones extremes, %0d failures",
               fail_count);
      if (fail_count == 0)
         $display("** scalar_kalman_estimator: PASSED **");
      else
         $display("** scalar_kalman_estimator: FAILED **");
      $finish;
   end

endmodule
